/* rtl/core/sv39ptw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sv39 page table walker package
// Shared types, field widths and codes for the walker and its step logic.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

   localparam int PA_W      = 56;
   localparam int VA_W      = 39;
   localparam int PTE_W     = 64;
   localparam int PPN_W     = 44;
   localparam int PG_SHIFT  = 12;
   localparam int IDX_BITS  = 9;
   localparam int LEVELS    = 3;
   localparam int LEVEL_W   = 2;
   localparam int PPN_LSB   = 10;

   localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS - 1);

   localparam int PTE_V = 0;
   localparam int PTE_R = 1;
   localparam int PTE_W_BIT = 2;
   localparam int PTE_X = 3;

   // request mode codes
   localparam logic MODE_TRANSLATE = 1'b0;
   localparam logic MODE_RESPONSE  = 1'b1;

   // result kind codes
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [VA_W-1:0]  vaddr;
      logic [PTE_W-1:0] entry_word;
   } req_type;

   typedef struct packed {
      logic            kind;
      logic [PA_W-1:0] read_addr;
      logic [PA_W-1:0] phys_addr;
      logic            fault;
   } rsp_type;

   typedef struct packed {
      logic               walking;
      logic [LEVEL_W-1:0] level;
      logic [PA_W-1:0]    table_base;
      logic [VA_W-1:0]    held_vaddr;
   } walk_state_type;

endpackage : sv39ptw_pkg
`default_nettype wire

/* rtl/core/sv39ptw_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sv39 walk step
// Judges one request against the walk state: starts a walk, descends a
// level, finishes with a physical address or a fault, or ignores a response while idle.
// ----------------------------------------------------------------------------
module sv39ptw_step
   import sv39ptw_pkg::*;
(
   input  req_type          req,
   input  walk_state_type   state,
   input  logic [PA_W-1:0]  root_pa,
   output walk_state_type   state_in,
   output logic             emit,
   output rsp_type          rsp
);

   logic [VA_W-1:0]     va;
   logic [PA_W-1:0]     base;
   logic [LEVEL_W-1:0]  lv;
   logic [LEVEL_W-1:0]  idx_lv;
   logic [IDX_BITS-1:0] idx;
   logic [PA_W-1:0]     entry_addr;
   logic [PPN_W-1:0]    ppn;
   logic [PA_W-1:0]     ppn_base;
   logic [PA_W-1:0]     offset;
   logic [PA_W-1:0]     leaf_pa;
   logic                pte_valid;
   logic                pte_terminal;

   assign ppn          = req.entry_word[PPN_LSB +: PPN_W];
   assign ppn_base     = {ppn, {PG_SHIFT{1'b0}}};
   assign pte_valid    = req.entry_word[PTE_V];
   assign pte_terminal = req.entry_word[PTE_R] | req.entry_word[PTE_W_BIT]
                       | req.entry_word[PTE_X];
   assign lv           = state.level;

   // address, table and level used for the next entry read
   assign va     = (req.mode == MODE_TRANSLATE) ? req.vaddr : state.held_vaddr;
   assign base   = (req.mode == MODE_TRANSLATE) ? root_pa : ppn_base;
   assign idx_lv = (req.mode == MODE_TRANSLATE) ? TOP_LEVEL : lv - 2'd1;

   // entry index slice of the held or incoming address
   always_comb begin
      idx = '0;
      case (idx_lv)
         2'd0:    idx = va[PG_SHIFT +: IDX_BITS];
         2'd1:    idx = va[PG_SHIFT + IDX_BITS +: IDX_BITS];
         2'd2:    idx = va[PG_SHIFT + 2*IDX_BITS +: IDX_BITS];
         default: idx = '0;
      endcase
   end

   assign entry_addr = base + {{(PA_W-IDX_BITS-3){1'b0}}, idx, 3'b000};

   // page offset for a leaf at the current level
   always_comb begin
      offset = '0;
      case (lv)
         2'd0:    offset = {{(PA_W-PG_SHIFT){1'b0}}, state.held_vaddr[PG_SHIFT-1:0]};
         2'd1:    offset = {{(PA_W-PG_SHIFT-IDX_BITS){1'b0}},
                            state.held_vaddr[PG_SHIFT+IDX_BITS-1:0]};
         2'd2:    offset = {{(PA_W-PG_SHIFT-2*IDX_BITS){1'b0}},
                            state.held_vaddr[PG_SHIFT+2*IDX_BITS-1:0]};
         default: offset = '0;
      endcase
   end

   assign leaf_pa = ppn_base + offset;

   always_comb begin
      state_in = state;
      emit     = 1'b0;
      rsp      = '0;
      if (req.mode == MODE_TRANSLATE) begin
         state_in.walking    = 1'b1;
         state_in.level      = TOP_LEVEL;
         state_in.table_base = root_pa;
         state_in.held_vaddr = req.vaddr;
         emit                = 1'b1;
         rsp.kind            = KIND_READ;
         rsp.read_addr       = entry_addr;
      end else if (state.walking) begin
         emit = 1'b1;
         if (!pte_valid || (!pte_terminal && lv == 2'd0)) begin
            state_in.walking = 1'b0;
            state_in.level   = TOP_LEVEL;
            rsp.kind         = KIND_DONE;
            rsp.fault        = 1'b1;
         end else if (pte_terminal) begin
            state_in.walking = 1'b0;
            state_in.level   = TOP_LEVEL;
            rsp.kind         = KIND_DONE;
            rsp.phys_addr    = leaf_pa;
         end else begin
            state_in.level      = lv - 2'd1;
            state_in.table_base = ppn_base;
            rsp.kind            = KIND_READ;
            rsp.read_addr       = entry_addr;
         end
      end
   end

endmodule : sv39ptw_step
`default_nettype wire

/* rtl/core/sv39_page_table_walker_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sv39 page table walker
// Three-level Sv39 walk driven by translate requests and memory responses.
//
//   channel   dir   ports                             payload
//   req       in    req_valid/req_ready/req_data      mode, vaddr, entry_word
//   rsp       out   rsp_valid/rsp_ready/rsp_data      kind, read_addr, phys_addr,
//                                                     fault
//   csr       in    csr_valid/csr_ready/csr_root_table_pa   root table address
//
// One request per cycle while req_ready is high; its result sits in the output register
// in the cycle after acceptance. Walk state updates at acceptance, from one step unit.
// req_ready drops only while a result waits and rsp_ready is low.
// A response arriving with no walk in progress is dropped without a result.
// Synchronous reset returns the walker to idle and clears the root address.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_top
   import sv39ptw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [PA_W-1:0]  csr_root_table_pa
);

   walk_state_type  state_ff, state_in;
   logic [PA_W-1:0] root_pa_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;
   rsp_type         step_rsp;
   logic            step_emit;
   logic            req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   sv39ptw_step u_step (
      .req      (req_data),
      .state    (state_ff),
      .root_pa  (root_pa_ff),
      .state_in (state_in),
      .emit     (step_emit),
      .rsp      (step_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (req_fire && step_emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.walking    <= 1'b0;
         state_ff.level      <= TOP_LEVEL;
         state_ff.table_base <= '0;
         state_ff.held_vaddr <= '0;
         root_pa_ff          <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            root_pa_ff <= csr_root_table_pa;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // checks
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.level != 2'd3)
      else $error("walk level out of range");

   a_translate_reads: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.mode == MODE_TRANSLATE) |=>
         (rsp_valid_ff && rsp_ff.kind == KIND_READ && state_ff.walking
          && state_ff.level == TOP_LEVEL))
      else $error("translate did not start a walk");

   a_idle_response_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.mode == MODE_RESPONSE && !state_ff.walking) |=>
         (!rsp_valid_ff && !state_ff.walking))
      else $error("response while idle produced a result");

   a_done_idles: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step_emit && step_rsp.kind == KIND_DONE) |=>
         (!state_ff.walking && state_ff.level == TOP_LEVEL))
      else $error("walker not idle after finish");

   a_result_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_ff.kind == KIND_READ && !rsp_ff.fault && rsp_ff.phys_addr == '0)
          || (rsp_ff.kind == KIND_DONE && rsp_ff.read_addr == '0
              && (!rsp_ff.fault || rsp_ff.phys_addr == '0))))
      else $error("inconsistent result fields");

endmodule : sv39_page_table_walker_top
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sv39 page table walker testbench
// Drives translate requests and page table entries into the walker, predicts
// every memory read and translation result from a private copy of the walk
// state, and checks each result field by field under random stalls on both
// sides and a sequence of root table addresses.
// ----------------------------------------------------------------------------
import sv39ptw_pkg::*;

class walk_scoreboard;
   logic [PA_W-1:0]    root_pa;
   bit                 walking;
   logic [LEVEL_W-1:0] level;
   logic [PA_W-1:0]    table_base;
   logic [VA_W-1:0]    held_va;
   rsp_type            expected_q[$];
   int                 errors;

   function new();
      root_pa    = '0;
      walking    = 1'b0;
      level      = TOP_LEVEL;
      table_base = '0;
      held_va    = '0;
      errors     = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void set_root(logic [PA_W-1:0] pa);
      root_pa = pa;
   endfunction

   function logic [PA_W-1:0] entry_addr();
      logic [IDX_BITS-1:0] idx;
      idx = IDX_BITS'(held_va >> (PG_SHIFT + IDX_BITS * int'(level)));
      return table_base + (PA_W'(idx) << 3);
   endfunction

   function void push_read();
      rsp_type e;
      e = '0;
      e.kind = KIND_READ;
      e.read_addr = entry_addr();
      expected_q.push_back(e);
   endfunction

   function void push_done(logic [PA_W-1:0] pa, logic flt);
      rsp_type e;
      e = '0;
      e.kind = KIND_DONE;
      e.phys_addr = flt ? '0 : pa;
      e.fault = flt;
      walking = 1'b0;
      level = TOP_LEVEL;
      expected_q.push_back(e);
   endfunction

   function void note_request(req_type r);
      logic [PPN_W-1:0] ppn;
      logic [VA_W-1:0]  off_mask;
      int               shift;
      if (r.mode == MODE_TRANSLATE) begin
         held_va    = r.vaddr;
         table_base = root_pa;
         level      = TOP_LEVEL;
         walking    = 1'b1;
         push_read();
         return;
      end
      if (!walking) return;
      ppn      = r.entry_word[PPN_LSB +: PPN_W];
      shift    = PG_SHIFT + IDX_BITS * int'(level);
      off_mask = (VA_W'(1) << shift) - VA_W'(1);
      if (!r.entry_word[PTE_V]) begin
         push_done('0, 1'b1);
      end else if (r.entry_word[PTE_R] || r.entry_word[PTE_W_BIT] || r.entry_word[PTE_X]) begin
         push_done({ppn, {PG_SHIFT{1'b0}}} + PA_W'(held_va & off_mask), 1'b0);
      end else if (level == '0) begin
         push_done('0, 1'b1);
      end else begin
         table_base = {ppn, {PG_SHIFT{1'b0}}};
         level = level - 1'b1;
         push_read();
      end
   endfunction

   task report(string msg);
      if (errors < 50) $display("ERROR: %s", msg);
      errors++;
   endtask

   task check_result(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         report($sformatf("unexpected result %h", got));
         return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)
         report($sformatf("kind %h, expected %h", got.kind, want.kind));
      if (got.read_addr !== want.read_addr)
         report($sformatf("read_addr %h, expected %h", got.read_addr, want.read_addr));
      if (got.phys_addr !== want.phys_addr)
         report($sformatf("phys_addr %h, expected %h", got.phys_addr, want.phys_addr));
      if (got.fault !== want.fault)
         report($sformatf("fault %h, expected %h", got.fault, want.fault));
   endtask
endclass

module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 80;

   typedef enum {FORM_INVALID, FORM_POINTER, FORM_LEAF} pte_form_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_type         req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_type         rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [PA_W-1:0] csr_root_table_pa = '0;

   logic            calm = 1'b0;
   int              cycle_count = 0;
   int              walk_items;
   walk_scoreboard  walk_sb = new();

   sv39_page_table_walker_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_root_table_pa (csr_root_table_pa)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) walk_sb.set_root(csr_root_table_pa);
         if (req_valid && req_ready) walk_sb.note_request(req_data);
         if (rsp_valid && rsp_ready) walk_sb.check_result(rsp_data);
      end
   end

   function automatic req_type translate_req(logic [VA_W-1:0] va);
      req_type r;
      r = '0;
      r.mode = MODE_TRANSLATE;
      r.vaddr = va;
      r.entry_word = {$urandom, $urandom};
      return r;
   endfunction

   function automatic req_type entry_req(logic [PTE_W-1:0] word);
      req_type r;
      r = '0;
      r.mode = MODE_RESPONSE;
      r.vaddr = VA_W'({$urandom, $urandom});
      r.entry_word = word;
      return r;
   endfunction

   function automatic logic [PTE_W-1:0] pte_word(logic [PPN_W-1:0] ppn, logic [9:0] flags);
      return {10'h3FF, ppn, flags};
   endfunction

   function automatic logic [PTE_W-1:0] random_pte(pte_form_type form);
      logic [PTE_W-1:0] w;
      w = {$urandom, $urandom};
      case (form)
         FORM_INVALID: begin
            w[PTE_V] = 1'b0;
         end
         FORM_POINTER: begin
            w[PTE_V] = 1'b1;
            w[PTE_X:PTE_R] = 3'b000;
         end
         default: begin
            w[PTE_V] = 1'b1;
            w[PTE_X:PTE_R] = 3'($urandom_range(7, 1));
         end
      endcase
      return w;
   endfunction

   function automatic logic [VA_W-1:0] random_va();
      case ($urandom_range(19))
         0: return '0;
         1: return '1;
         default: return VA_W'({$urandom, $urandom});
      endcase
   endfunction

   task automatic send_request(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!calm && $urandom_range(99) < 5) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic write_root(input logic [PA_W-1:0] pa);
      csr_valid         <= 1'b1;
      csr_root_table_pa <= pa;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (walk_sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_walk();
      int               end_level;
      int               outcome;
      logic [PTE_W-1:0] word;
      end_level = $urandom_range(2);
      outcome   = $urandom_range(9);
      send_request(translate_req(random_va()));
      walk_items++;
      for (int lvl = 2; lvl >= end_level; lvl--) begin
         // abandoned walk: the next translate restarts from the root
         if ($urandom_range(19) == 0) return;
         if (lvl > end_level) word = random_pte(FORM_POINTER);
         else if (outcome < 6) word = random_pte(FORM_LEAF);
         else if (outcome < 8) word = random_pte(FORM_INVALID);
         else if (end_level == 0) word = random_pte(FORM_POINTER);
         else word = random_pte(pte_form_type'($urandom_range(2)));
         send_request(entry_req(word));
         walk_items++;
      end
      // extra response, which may arrive with no walk in progress
      if ($urandom_range(9) == 0)
         send_request(entry_req(random_pte(pte_form_type'($urandom_range(2)))));
   endtask

   initial begin
      logic [PA_W-1:0] root;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset root, all levels, faults, abandon, wrap-around
      send_request(entry_req('1));
      send_request(translate_req('0));
      send_request(entry_req(pte_word('1, 10'h001)));
      send_request(entry_req(pte_word('0, 10'h001)));
      send_request(entry_req(pte_word(44'h123, 10'h003)));
      send_request(translate_req('1));
      send_request(entry_req(pte_word('1, 10'h009)));
      send_request(translate_req(VA_W'(39'h2A_5A5A_5A5A)));
      send_request(entry_req('0));
      send_request(translate_req(VA_W'(39'h55_A5A5_A5A5)));
      send_request(entry_req(pte_word(44'hABC_DEF0_1234, 10'h001)));
      send_request(entry_req(pte_word('1, 10'h3F0)));
      send_request(translate_req('1));
      send_request(entry_req(pte_word('1, 10'h3F1)));
      send_request(entry_req(pte_word('0, 10'h001)));
      send_request(entry_req(pte_word('1, 10'h001)));
      send_request(entry_req(pte_word('1, 10'h00F)));
      send_request(translate_req(VA_W'(39'h12_3456_789A)));
      send_request(entry_req(pte_word(44'h5_5555_5555, 10'h001)));
      send_request(translate_req('1));
      send_request(entry_req(pte_word(44'h7, 10'h005)));
      send_request(translate_req('1));
      send_request(entry_req(pte_word('0, 10'h001)));
      send_request(entry_req('1));
      wait_idle();
      write_root('1);
      send_request(translate_req('1));
      send_request(entry_req('1));

      for (int p = 0; p < 5; p++) begin
         wait_idle();
         case (p)
            0: root = '0;
            1: root = '1;
            default: root = PA_W'({$urandom, $urandom});
         endcase
         calm <= (p == 2);
         write_root(root);
         walk_items = 0;
         while (walk_items < PHASE_ITEMS) run_walk();
      end

      wait_idle();
      if (walk_sb.errors == 0 && walk_sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sv39_page_table_walker_top.f */
rtl/core/sv39ptw_pkg.sv
rtl/core/sv39ptw_step.sv
rtl/core/sv39_page_table_walker_top.sv
test/testbench.sv
